// ===== src/dmwbc_pkg.sv =====
package dmwbc_pkg;

    localparam int LINE_COUNT_DEF  = 256;
    localparam int BLOCK_BYTES_DEF = 64;
    localparam int MEM_BYTES_DEF   = 65536;
    localparam int WORD_BYTES      = 4;
    localparam int ADDR_W          = 16;
    localparam int WORD_W          = 32;
    localparam int LAT_W           = 16;
    localparam int TIME_W          = 32;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEM_READ    = 2'd0,
        REG_MEM_WRITE   = 2'd1,
        REG_CACHE_READ  = 2'd2,
        REG_CACHE_WRITE = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EVICT,
        ST_FILL,
        ST_ACCESS,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              is_write;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } req_t;

endpackage

// ===== src/dmwbc_front.sv =====
module dmwbc_front
    import dmwbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_req,
    output logic        q_valid,
    input  logic        q_ready,
    output req_t        q_req
);

    req_t buf_reg [2];
    logic [1:0] cnt_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg].is_write <= in_req.is_write;
            buf_reg[wr_ptr_reg].addr     <= {in_req.addr[ADDR_W-1:2], 2'b00};
            buf_reg[wr_ptr_reg].wdata    <= in_req.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== src/dmwbc_back.sv =====
module dmwbc_back
    import dmwbc_pkg::*;
#(
    parameter int LINE_COUNT  = LINE_COUNT_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int MEM_BYTES   = MEM_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  req_t              q_req,
    input  logic [LAT_W-1:0]  lat_mem_rd,
    input  logic [LAT_W-1:0]  lat_mem_wr,
    input  logic [LAT_W-1:0]  lat_c_rd,
    input  logic [LAT_W-1:0]  lat_c_wr,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_rdata,
    output logic              out_hit,
    output logic [TIME_W-1:0] out_time
);

    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int IDX_W  = $clog2(LINE_COUNT);
    localparam int MADR_W = $clog2(MEM_BYTES);
    localparam int BW_W   = OFF_W - 2;
    localparam int BWORDS = BLOCK_BYTES / WORD_BYTES;
    localparam int TAG_W  = (MADR_W > OFF_W + IDX_W) ? MADR_W - OFF_W - IDX_W : 1;
    localparam int CW_W   = IDX_W + BW_W;
    localparam int MW_W   = MADR_W - 2;
    localparam int CWORDS = LINE_COUNT * BWORDS;
    localparam int MWORDS = MEM_BYTES / WORD_BYTES;

    logic [WORD_W-1:0] cmem [CWORDS];
    logic [WORD_W-1:0] bmem [MWORDS];
    logic [LINE_COUNT-1:0] valid_reg, dirty_reg;
    logic [TAG_W-1:0]  tag_mem [LINE_COUNT];

    state_t state_reg, state_next;
    req_t   req_reg;
    logic   hit_reg;
    logic [TAG_W-1:0]  vtag_reg;
    logic [BW_W:0]     cnt_reg, cnt_next;
    logic [MW_W:0]     clr_reg;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [WORD_W-1:0] rdata_reg;
    logic [WORD_W-1:0] crd_reg, brd_reg;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_rdata_reg;
    logic              out_hit_reg;
    logic [TIME_W-1:0] out_time_reg;

    logic [MADR_W-1:0] addr;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  q_idx;
    logic [BW_W-1:0]   wib;
    logic [TAG_W-1:0]  tag;
    logic              take;
    logic              rd_word_ok;
    logic              lookup_hit;
    logic              lookup_dirty;
    logic              load_out;

    assign addr  = MADR_W'(req_reg.addr);
    assign idx   = addr[OFF_W +: IDX_W];
    assign q_idx = IDX_W'(MADR_W'(q_req.addr) >> OFF_W);
    assign wib   = addr[2 +: BW_W];
    assign tag   = (MADR_W > OFF_W + IDX_W) ? TAG_W'(addr >> (OFF_W + IDX_W)) : '0;

    assign lookup_hit   = valid_reg[idx] && (vtag_reg == tag);
    assign lookup_dirty = valid_reg[idx] && dirty_reg[idx];

    assign q_ready   = (state_reg == ST_IDLE);
    assign take      = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign out_rdata = out_rdata_reg;
    assign out_hit   = out_hit_reg;
    assign out_time  = out_time_reg;

    assign load_out       = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign out_valid_next = load_out ? 1'b1 : (out_valid_reg && !out_ready);

    // evict: cnt steps read cache into crd_reg, memory is written from crd_reg
    // fill: cnt steps read memory into brd_reg, cache is written from brd_reg
    logic [BW_W-1:0] step;
    logic            wr_phase;
    assign step     = cnt_reg[BW_W-1:0];
    assign wr_phase = (cnt_reg != '0);

    logic [BW_W-1:0] prev;
    assign prev = step - BW_W'(1);

    logic [MW_W-1:0] vbase, fbase;
    assign vbase = MW_W'({vtag_reg, idx, {BW_W{1'b0}}});
    assign fbase = MW_W'({tag, idx, {BW_W{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            bmem[clr_reg[MW_W-1:0]] <= '0;
        else if (state_reg == ST_EVICT && wr_phase)
            bmem[vbase | MW_W'(prev)] <= crd_reg;
        if (state_reg == ST_FILL)
            brd_reg <= bmem[fbase | MW_W'(step)];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FILL && wr_phase)
            cmem[{idx, prev}] <= brd_reg;
        else if (state_reg == ST_ACCESS && req_reg.is_write)
            cmem[{idx, wib}] <= req_reg.wdata;
        if (state_reg == ST_EVICT)
            crd_reg <= cmem[{idx, step}];
        else
            crd_reg <= cmem[{idx, wib}];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg  <= q_req;
            vtag_reg <= tag_mem[q_idx];
        end
        if (state_reg == ST_LOOKUP)
            tag_mem[idx] <= tag;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        time_next  = time_reg;
        rd_word_ok = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == MW_W'(MWORDS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (take)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                cnt_next = '0;
                if (lookup_hit)
                    state_next = ST_ACCESS;
                else
                begin
                    time_next = time_reg + TIME_W'(lat_mem_rd);
                    if (lookup_dirty)
                    begin
                        time_next  = time_reg + TIME_W'(lat_mem_rd) + TIME_W'(lat_mem_wr);
                        state_next = ST_EVICT;
                    end
                    else
                        state_next = ST_FILL;
                end
            end
            ST_EVICT:
            begin
                cnt_next = cnt_reg + (BW_W+1)'(1);
                if (cnt_reg == (BW_W+1)'(BWORDS))
                begin
                    cnt_next   = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                cnt_next = cnt_reg + (BW_W+1)'(1);
                if (cnt_reg == (BW_W+1)'(BWORDS))
                    state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                // crd_reg may be stale after fill, so a read waits for it to be reloaded
                if (cnt_reg == '0 || req_reg.is_write)
                begin
                    rd_word_ok = 1'b1;
                    time_next  = time_reg + TIME_W'(req_reg.is_write ? lat_c_wr : lat_c_rd);
                    state_next = ST_DONE;
                end
                else
                    cnt_next = '0;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            time_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_rdata_reg <= '0;
            out_hit_reg   <= 1'b0;
            out_time_reg  <= '0;
            hit_reg       <= 1'b0;
            rdata_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + (MW_W+1)'(1);
            if (state_reg == ST_LOOKUP)
            begin
                hit_reg        <= lookup_hit;
                valid_reg[idx] <= 1'b1;
                if (!lookup_hit)
                    dirty_reg[idx] <= 1'b0;
            end
            if (rd_word_ok)
            begin
                if (req_reg.is_write)
                begin
                    dirty_reg[idx] <= 1'b1;
                    rdata_reg      <= '0;
                end
                else
                    rdata_reg <= crd_reg;
            end
            if (load_out)
            begin
                out_rdata_reg <= rdata_reg;
                out_hit_reg   <= hit_reg;
                out_time_reg  <= time_reg;
            end
        end
    end

endmodule

// ===== src/direct_mapped_writeback_cache.sv =====
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata: operation, byte_address, write_word
// m_axis    out  m_axis_tvalid/tready        tdata: read_word, was_hit, elapsed_time
// cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
// a hit passes the back end through take, lookup, access and done
// a miss adds a fill state that moves every word of the block, and a read after a fill waits in access for crd_reg
// a dirty victim first adds an evict state that writes every word of the block back
// after reset the backing memory is cleared, one word a cycle
// the input queue holds two beats; the result register holds one
module direct_mapped_writeback_cache
    import dmwbc_pkg::*;
#(
    parameter int LINE_COUNT  = LINE_COUNT_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int MEM_BYTES   = MEM_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,  // operation, byte_address, write_word
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [71:0]          m_axis_tdata,  // read_word, was_hit, elapsed_time
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LAT_W-1:0]     cfg_data
);

    logic [LAT_W-1:0] lat_mem_rd_reg, lat_mem_wr_reg, lat_c_rd_reg, lat_c_wr_reg;
    req_t in_req, q_req;
    logic q_valid, q_ready;
    logic [WORD_W-1:0] rdata;
    logic hit;
    logic [TIME_W-1:0] tm;

    assign cfg_ready = 1'b1;
    assign in_req.is_write = s_axis_tdata[0];
    assign in_req.addr     = s_axis_tdata[16:1];
    assign in_req.wdata    = s_axis_tdata[48:17];
    assign m_axis_tdata    = {7'd0, tm, hit, rdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_mem_rd_reg <= 16'd100;
            lat_mem_wr_reg <= 16'd50;
            lat_c_rd_reg   <= 16'd1;
            lat_c_wr_reg   <= 16'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MEM_READ:    lat_mem_rd_reg <= cfg_data;
                REG_MEM_WRITE:   lat_mem_wr_reg <= cfg_data;
                REG_CACHE_READ:  lat_c_rd_reg   <= cfg_data;
                REG_CACHE_WRITE: lat_c_wr_reg   <= cfg_data;
                default:         lat_c_wr_reg   <= lat_c_wr_reg;
            endcase
        end
    end

    dmwbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    dmwbc_back #(
        .LINE_COUNT  (LINE_COUNT),
        .BLOCK_BYTES (BLOCK_BYTES),
        .MEM_BYTES   (MEM_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_req      (q_req),
        .lat_mem_rd (lat_mem_rd_reg),
        .lat_mem_wr (lat_mem_wr_reg),
        .lat_c_rd   (lat_c_rd_reg),
        .lat_c_wr   (lat_c_wr_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_rdata  (rdata),
        .out_hit    (hit),
        .out_time   (tm)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench
    import dmwbc_pkg::*;
();

    localparam int LINES       = 256;
    localparam int BLK_WORDS   = 16;
    localparam int MEM_WORDS   = 16384;
    localparam int DRAIN_WAIT  = 200;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [55:0]          s_axis_tdata;   // operation, byte_address, write_word
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [71:0]          m_axis_tdata;   // read_word, was_hit, elapsed_time
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LAT_W-1:0]     cfg_data;

    typedef struct packed {
        logic [WORD_W-1:0] rdata;
        logic              hit;
        logic [TIME_W-1:0] elapsed;
    } access_result_t;

    // predictor state
    logic [LAT_W-1:0]  lat_fill, lat_evict, lat_rd, lat_wr;
    logic              ln_valid [LINES];
    logic              ln_dirty [LINES];
    logic [1:0]        ln_tag   [LINES];
    logic [WORD_W-1:0] line_data [LINES*BLK_WORDS];
    logic [WORD_W-1:0] backing  [MEM_WORDS];
    logic [TIME_W-1:0] clock_sum;

    access_result_t pending_results[$];
    int  fail_count;
    bit  allow_idle;

    direct_mapped_writeback_cache dut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic access_result_t predict_access(op_t op, logic [15:0] addr,
                                                      logic [31:0] wdata);
        access_result_t r;
        logic [7:0]  idx;
        logic [1:0]  tg;
        logic [3:0]  woff;
        int          base;
        int          vbase;
        int          fbase;
        idx   = addr[13:6];
        tg    = addr[15:14];
        woff  = addr[5:2];
        base  = idx * BLK_WORDS;
        r     = '0;
        r.hit = ln_valid[idx] && ln_tag[idx] == tg;
        if (!r.hit)
        begin
            clock_sum += lat_fill;
            if (ln_valid[idx] && ln_dirty[idx])
            begin
                vbase = {ln_tag[idx], idx, 4'b0};
                for (int i = 0; i < BLK_WORDS; i++)
                    backing[vbase + i] = line_data[base + i];
                clock_sum += lat_evict;
            end
            fbase = {tg, idx, 4'b0};
            for (int i = 0; i < BLK_WORDS; i++)
                line_data[base + i] = backing[fbase + i];
            ln_valid[idx] = 1'b1;
            ln_tag[idx]   = tg;
            ln_dirty[idx] = 1'b0;
        end
        if (op == OP_WRITE)
        begin
            line_data[base + woff] = wdata;
            ln_dirty[idx] = 1'b1;
            clock_sum += lat_wr;
        end
        else
        begin
            r.rdata = line_data[base + woff];
            clock_sum += lat_rd;
        end
        r.elapsed = clock_sum;
        return r;
    endfunction

    task automatic idle_gap();
        if (allow_idle && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic send_access(op_t op, logic [15:0] addr, logic [31:0] wdata);
        idle_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {wdata, addr, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(predict_access(op, addr, wdata));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_latency(cfg_reg_t reg_id, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_id;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (reg_id)
            REG_MEM_READ:    lat_fill  = value;
            REG_MEM_WRITE:   lat_evict = value;
            REG_CACHE_READ:  lat_rd    = value;
            REG_CACHE_WRITE: lat_wr    = value;
            default: ;
        endcase
    endtask

    task automatic set_latencies(logic [15:0] f, logic [15:0] e, logic [15:0] rd,
                                 logic [15:0] wr);
        wait_drained();
        write_latency(REG_MEM_READ, f);
        write_latency(REG_MEM_WRITE, e);
        write_latency(REG_CACHE_READ, rd);
        write_latency(REG_CACHE_WRITE, wr);
        cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        access_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[64:33]};
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected beat: actual %h", $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.rdata !== want.rdata)
                begin
                    $display("%0t read_word: expected %h actual %h", $time,
                             want.rdata, got.rdata);
                    fail_count++;
                end
                if (got.hit !== want.hit)
                begin
                    $display("%0t was_hit: expected %0d actual %0d", $time,
                             want.hit, got.hit);
                    fail_count++;
                end
                if (got.elapsed !== want.elapsed)
                begin
                    $display("%0t elapsed_time: expected %0d actual %0d", $time,
                             want.elapsed, got.elapsed);
                    fail_count++;
                end
            end
        end
    end

    // result side stalls
    always @(posedge clk)
    begin
        int stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b1;
        end
        else if (allow_idle && m_axis_tready && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall = $urandom_range(1, 16);
            repeat (stall) @(posedge clk);
            m_axis_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_access(OP_READ,  16'h0000, 32'h0);
        send_access(OP_WRITE, 16'h0003, 32'hFFFF_FFFF);
        send_access(OP_READ,  16'h0001, 32'h0);
        send_access(OP_WRITE, 16'hFFFF, 32'hA5A5_5A5A);
        send_access(OP_READ,  16'hFFFC, 32'h0);
        send_access(OP_WRITE, 16'h4000, 32'h1234_5678);  // evicts dirty line 0
        send_access(OP_READ,  16'h0000, 32'h0);          // refill from memory
        send_access(OP_READ,  16'h8000, 32'h0);          // clean victim, no write-back
        send_access(OP_WRITE, 16'h7FFE, 32'h0000_0001);
        send_access(OP_WRITE, 16'h3FC0, 32'h8000_0000);
        send_access(OP_READ,  16'hBFC0, 32'h0);
        send_access(OP_READ,  16'h3FC0, 32'h0);
        send_access(OP_READ,  16'h4000, 32'h0);
    endtask

    task automatic test_latency_extremes();
        set_latencies(16'h0, 16'h0, 16'h0, 16'h0);
        for (int i = 0; i < 4; i++)
            send_access(op_t'(i[0]), {i[1:0], 14'h0040}, $urandom);
        set_latencies(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // largest latencies on every access
        for (int i = 0; i < 40000; i += 1000)
            send_access(op_t'($urandom_range(0, 1)), 16'($urandom), $urandom);
        set_latencies(16'd100, 16'd50, 16'd1, 16'd1);
    endtask

    task automatic test_random(int count);
        logic [15:0] addr;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_drained();
            if (i == count - 150)
                allow_idle = 1'b0;
            // mostly 64 hot lines so hits, conflicts and write-backs all occur
            if ($urandom_range(0, 3) != 0)
                addr = {2'($urandom), 4'($urandom_range(0, 3)), 4'($urandom), 6'($urandom)};
            else
                addr = 16'($urandom);
            send_access(op_t'($urandom_range(0, 1)), addr, $urandom);
            if (i == count / 3)
                set_latencies(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_MEM_READ;
        cfg_data      = '0;
        fail_count    = 0;
        allow_idle    = 1'b1;
        lat_fill      = 16'd100;
        lat_evict     = 16'd50;
        lat_rd        = 16'd1;
        lat_wr        = 16'd1;
        clock_sum     = '0;
        for (int i = 0; i < LINES; i++)
        begin
            ln_valid[i] = 1'b0;
            ln_dirty[i] = 1'b0;
            ln_tag[i]   = '0;
        end
        for (int i = 0; i < LINES*BLK_WORDS; i++)
            line_data[i] = '0;
        for (int i = 0; i < MEM_WORDS; i++)
            backing[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_latency_extremes();
        test_random(1450);
        wait_drained();
        if (fail_count == 0)
            $display("direct_mapped_writeback_cache regression: pass");
        else
            $display("direct_mapped_writeback_cache regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("direct_mapped_writeback_cache regression: fail");
        $finish;
    end

endmodule
